// ===== rtl/vmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vmb_pkg;

  localparam int MAX_BLOCK  = 1024;
  localparam int Q_W        = 25;
  localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W      = Q_W + CNT_W;
  localparam int DIV_STEP_W = $clog2(SUM_W);
  localparam int ERR_W      = Q_W + 1;
  localparam int INR_W      = 41;
  localparam int ACC_E_W    = Q_W + 2;
  localparam int ACC_I_W    = INR_W + 1;
  localparam int POS_W      = INR_W + 3;
  localparam int FRAC_W     = 24;
  localparam int MUL_A_W    = FRAC_W;
  localparam int MUL_P_W    = MUL_A_W + Q_W;
  localparam int MUL_STEPS  = 4;
  localparam int MSTEP_W    = $clog2(MUL_STEPS + 1);

  localparam int BQ_DEPTH   = 4;
  localparam int BQ_PTR_W   = $clog2(BQ_DEPTH);
  localparam int BQ_CNT_W   = BQ_PTR_W + 1;

  localparam int OQ_DEPTH   = 2;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = OQ_PTR_W + 1;

  localparam int APB_DW     = 32;
  localparam int APB_AW     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [Q_W-1:0] Q24_ONE = Q_W'(1 << FRAC_W);

  localparam logic [REG_IDX_W-1:0] REG_GAIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RISE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FALL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PCOEF = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ICOEF = 3'd4;

  localparam logic [Q_W-1:0] GAIN_RST  = 25'd19399898;
  localparam logic [Q_W-1:0] RISE_RST  = 25'd2330;
  localparam logic [Q_W-1:0] FALL_RST  = 25'd1165;
  localparam logic [Q_W-1:0] PCOEF_RST = 25'd503316;
  localparam logic [Q_W-1:0] ICOEF_RST = 25'd8389;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [Q_W-1:0] needle_pos;
    logic [Q_W-1:0] block_level;
    logic           overflow;
  } out_t;

  typedef struct packed {
    logic [Q_W-1:0] gain;
    logic [Q_W-1:0] rise;
    logic [Q_W-1:0] fall;
    logic [Q_W-1:0] pcoef;
    logic [Q_W-1:0] icoef;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } blk_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_ERR,
    B_MUL,
    B_POS,
    B_PUSH
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/vu_meter_ballistics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// VU meter with slew-limited peak follower and PI needle model. Samples are
// taken one per cycle while in_full is low, through a front of magnitude,
// gain multiply, follower step and block sum. Each sample marked last hands
// its block total to a four-entry block queue. The back end works one block
// at a time: a restoring divide for the mean level, then error and inertia,
// four passes through one shared 24x25 multiplier, the position clamp and the
// push into a two-entry result queue. Blocks shorter than the back end's work
// per block fill the block queue and in_full is raised until the back end
// catches up; in_full is also raised while queued plus in-flight blocks fill
// the queue.
// Registers come out of reset at their defaults and are written at byte
// address 4*index; write them only while the block is idle.
module vu_meter_ballistics (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  vmb_pkg::in_t               in_data,
  output logic                       out_empty,
  input  logic                       out_pop,
  output vmb_pkg::out_t              out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [vmb_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [vmb_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [vmb_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import vmb_pkg::*;

  cfg_t                regs;
  logic                bq_push, bq_pop, bq_empty;
  blk_t                bq_din, bq_dout;
  logic [BQ_CNT_W-1:0] bq_count;

  vmb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  vmb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .regs     (regs),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .bq_count (bq_count),
    .bq_push  (bq_push),
    .bq_data  (bq_din)
  );

  vmb_blk_fifo u_bq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bq_push),
    .din   (bq_din),
    .pop   (bq_pop),
    .dout  (bq_dout),
    .empty (bq_empty),
    .count (bq_count)
  );

  vmb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .bq_empty  (bq_empty),
    .bq_data   (bq_dout),
    .bq_pop    (bq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/vmb_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vmb_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [vmb_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [vmb_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [vmb_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output vmb_pkg::cfg_t              regs
);
  import vmb_pkg::*;

  cfg_t                 regs_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;
  logic [Q_W-1:0]       rd_val;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[APB_AW-1:2];
  assign regs       = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.gain  <= GAIN_RST;
      regs_r.rise  <= RISE_RST;
      regs_r.fall  <= FALL_RST;
      regs_r.pcoef <= PCOEF_RST;
      regs_r.icoef <= ICOEF_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN:  regs_r.gain  <= cfg_pwdata[Q_W-1:0];
        REG_RISE:  regs_r.rise  <= cfg_pwdata[Q_W-1:0];
        REG_FALL:  regs_r.fall  <= cfg_pwdata[Q_W-1:0];
        REG_PCOEF: regs_r.pcoef <= cfg_pwdata[Q_W-1:0];
        REG_ICOEF: regs_r.icoef <= cfg_pwdata[Q_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN:  rd_val = regs_r.gain;
      REG_RISE:  rd_val = regs_r.rise;
      REG_FALL:  rd_val = regs_r.fall;
      REG_PCOEF: rd_val = regs_r.pcoef;
      REG_ICOEF: rd_val = regs_r.icoef;
      default:   rd_val = '0;
    endcase
  end

  assign cfg_prdata = APB_DW'(rd_val);

endmodule
`default_nettype wire

// ===== rtl/vmb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vmb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vmb_pkg::cfg_t                regs,
  input  logic                         in_push,
  output logic                         in_full,
  input  vmb_pkg::in_t                 in_data,
  input  logic [vmb_pkg::BQ_CNT_W-1:0] bq_count,
  output logic                         bq_push,
  output vmb_pkg::blk_t                bq_data
);
  import vmb_pkg::*;

  logic             a_v_r, a_last_r;
  logic [16:0]      a_abs_r;
  logic             b_v_r, b_last_r;
  logic [Q_W-1:0]   b_mag_r;
  logic             c_v_r, c_last_r;
  logic [Q_W-1:0]   follower_r, follower_nxt;
  logic [SUM_W-1:0] sum_r, sum_upd;
  logic [CNT_W-1:0] cnt_r, cnt_upd;
  logic             ovf_r, ovf_upd;

  logic             accept;
  logic [16:0]      s_ext;
  logic [41:0]      mprod;
  logic [Q_W-1:0]   diff, stp;
  logic             room;
  logic [BQ_CNT_W:0] pending;

  // blocks still in the pipe need a guaranteed slot in the block queue
  assign pending = (BQ_CNT_W+1)'(bq_count)
                 + (BQ_CNT_W+1)'(a_v_r & a_last_r)
                 + (BQ_CNT_W+1)'(b_v_r & b_last_r)
                 + (BQ_CNT_W+1)'(c_v_r & c_last_r);
  assign in_full = (pending >= (BQ_CNT_W+1)'(BQ_DEPTH));
  assign accept  = in_push & ~in_full;

  assign s_ext = {in_data.sample[15], in_data.sample};
  assign mprod = 42'(a_abs_r) * 42'(regs.gain);

  always_comb begin
    if (b_mag_r >= follower_r) begin
      diff         = b_mag_r - follower_r;
      stp          = (diff < regs.rise) ? diff : regs.rise;
      follower_nxt = follower_r + stp;
    end else begin
      diff         = follower_r - b_mag_r;
      stp          = (diff < regs.fall) ? diff : regs.fall;
      follower_nxt = follower_r - stp;
    end
  end

  assign room    = (cnt_r < CNT_W'(MAX_BLOCK));
  assign sum_upd = room ? (sum_r + SUM_W'(follower_r)) : sum_r;
  assign cnt_upd = room ? (cnt_r + 1'b1) : cnt_r;
  assign ovf_upd = ovf_r | ~room;

  assign bq_push     = c_v_r & c_last_r;
  assign bq_data.sum = sum_upd;
  assign bq_data.cnt = cnt_upd;
  assign bq_data.ovf = ovf_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
      c_v_r      <= 1'b0;
      follower_r <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
    end else begin
      a_v_r <= accept;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      if (b_v_r) begin
        follower_r <= follower_nxt;
      end
      if (c_v_r) begin
        if (c_last_r) begin
          sum_r <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          sum_r <= sum_upd;
          cnt_r <= cnt_upd;
          ovf_r <= ovf_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_last_r <= in_data.last;
    a_abs_r  <= s_ext[16] ? (~s_ext + 1'b1) : s_ext;
    b_last_r <= a_last_r;
    b_mag_r  <= mprod[39:15];
    c_last_r <= b_last_r;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BLOCK))
    else $error("sample count beyond block limit");

  a_bq_room: assert property (@(posedge clk) disable iff (!rst_n)
    bq_push |-> bq_count < BQ_CNT_W'(BQ_DEPTH))
    else $error("block pushed into full queue");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == CNT_W'(MAX_BLOCK))
    else $error("overflow flagged before block limit reached");

endmodule
`default_nettype wire

// ===== rtl/vmb_blk_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vmb_blk_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  vmb_pkg::blk_t                din,
  input  logic                         pop,
  output vmb_pkg::blk_t                dout,
  output logic                         empty,
  output logic [vmb_pkg::BQ_CNT_W-1:0] count
);
  import vmb_pkg::*;

  blk_t                mem_r [BQ_DEPTH];
  logic [BQ_PTR_W-1:0] wp_r, rp_r;
  logic [BQ_CNT_W-1:0] cnt_r;
  logic                do_pop;

  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign dout   = mem_r[rp_r];
  assign do_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + BQ_CNT_W'(push) - BQ_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vmb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vmb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  vmb_pkg::cfg_t regs,
  input  logic          bq_empty,
  input  vmb_pkg::blk_t bq_data,
  output logic          bq_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output vmb_pkg::out_t out_data
);
  import vmb_pkg::*;

  back_state_t state_r, state_nxt;

  blk_t                    blk_r;
  logic [SUM_W-1:0]        quo_r;
  logic [CNT_W-1:0]        rem_r;
  logic [DIV_STEP_W-1:0]   step_r;
  logic [Q_W-1:0]          level_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [INR_W-1:0] inertia_r;
  logic [Q_W-1:0]          position_r;
  logic [MSTEP_W-1:0]      mstep_r;
  logic [1:0]              prev_r;
  logic [MUL_P_W-1:0]      prod_r;
  logic [ACC_E_W-1:0]      acc_e_r;
  logic [ACC_I_W-1:0]      acc_i_r;
  out_t                    res_r;

  out_t                    oq_mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]     oq_wp_r, oq_rp_r;
  logic [OQ_CNT_W-1:0]     oq_cnt_r;
  logic                    oq_full, oq_push, oq_pop;

  logic [CNT_W:0]          rem_sh;
  logic                    ge;
  logic [Q_W-1:0]          level_c;
  logic signed [ERR_W-1:0] err_c;
  logic signed [INR_W:0]   isum;
  logic signed [INR_W-1:0] inertia_c;
  logic [ERR_W-1:0]        mag_e;
  logic [INR_W-1:0]        mag_i;
  logic [MUL_A_W-1:0]      mul_a;
  logic [Q_W-1:0]          mul_b;
  logic [MUL_P_W-1:0]      term;
  logic signed [POS_W-1:0] se, si, pos_c;

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, blk_r.cnt});

  assign level_c = (blk_r.cnt == '0) ? '0 : quo_r[Q_W-1:0];
  assign err_c   = $signed({1'b0, level_c}) - $signed({1'b0, position_r});
  assign isum    = {inertia_r[INR_W-1], inertia_r} + (INR_W+1)'(err_c);

  always_comb begin
    if (isum[INR_W] != isum[INR_W-1]) begin
      inertia_c = isum[INR_W] ? {1'b1, {(INR_W-1){1'b0}}} : {1'b0, {(INR_W-1){1'b1}}};
    end else begin
      inertia_c = isum[INR_W-1:0];
    end
  end

  // magnitudes split into integer and fraction parts through one shared multiplier
  assign mag_e = err_r[ERR_W-1] ? (~err_r + 1'b1) : err_r;
  assign mag_i = inertia_r[INR_W-1] ? (~inertia_r + 1'b1) : inertia_r;

  always_comb begin
    unique case ({mstep_r[1], mstep_r[0]})
      2'b00: mul_a = MUL_A_W'(mag_e[ERR_W-1:FRAC_W]);
      2'b01: mul_a = mag_e[FRAC_W-1:0];
      2'b10: mul_a = MUL_A_W'(mag_i[INR_W-1:FRAC_W]);
      2'b11: mul_a = mag_i[FRAC_W-1:0];
    endcase
    mul_b = mstep_r[1] ? regs.icoef : regs.pcoef;
  end

  assign term = prev_r[0] ? (prod_r >> FRAC_W) : prod_r;

  always_comb begin
    se = $signed(POS_W'(acc_e_r));
    si = $signed(POS_W'(acc_i_r));
    if (err_r[ERR_W-1]) begin
      se = -se;
    end
    if (inertia_r[INR_W-1]) begin
      si = -si;
    end
    pos_c = $signed(POS_W'(position_r)) + se + si;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!bq_empty) state_nxt = B_DIV;
      B_DIV:  if (step_r == DIV_STEP_W'(SUM_W - 1)) state_nxt = B_ERR;
      B_ERR:  state_nxt = B_MUL;
      B_MUL:  if (mstep_r == MSTEP_W'(MUL_STEPS)) state_nxt = B_POS;
      B_POS:  state_nxt = B_PUSH;
      B_PUSH: if (!oq_full) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    bq_pop  = (state_r == B_IDLE) && !bq_empty;
    oq_push = (state_r == B_PUSH) && !oq_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      position_r <= '0;
      inertia_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_ERR) begin
        inertia_r <= inertia_c;
      end
      if (state_r == B_POS) begin
        if (pos_c <= 0) begin
          position_r <= '0;
          inertia_r  <= '0;
        end else if (pos_c >= $signed(POS_W'(Q24_ONE))) begin
          position_r <= Q24_ONE;
          inertia_r  <= '0;
        end else begin
          position_r <= pos_c[Q_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        blk_r  <= bq_data;
        quo_r  <= bq_data.sum;
        rem_r  <= '0;
        step_r <= '0;
      end
      B_DIV: begin
        quo_r  <= {quo_r[SUM_W-2:0], ge};
        rem_r  <= ge ? CNT_W'(rem_sh - {1'b0, blk_r.cnt}) : rem_sh[CNT_W-1:0];
        step_r <= step_r + 1'b1;
      end
      B_ERR: begin
        level_r <= level_c;
        err_r   <= err_c;
        acc_e_r <= '0;
        acc_i_r <= '0;
        mstep_r <= '0;
      end
      B_MUL: begin
        prod_r  <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        prev_r  <= mstep_r[1:0];
        mstep_r <= mstep_r + 1'b1;
        if (mstep_r != '0) begin
          if (prev_r[1]) begin
            acc_i_r <= acc_i_r + ACC_I_W'(term);
          end else begin
            acc_e_r <= acc_e_r + ACC_E_W'(term);
          end
        end
      end
      B_POS: begin
        res_r.block_level <= level_r;
        res_r.overflow    <= blk_r.ovf;
        if (pos_c <= 0) begin
          res_r.needle_pos <= '0;
        end else if (pos_c >= $signed(POS_W'(Q24_ONE))) begin
          res_r.needle_pos <= Q24_ONE;
        end else begin
          res_r.needle_pos <= pos_c[Q_W-1:0];
        end
      end
      B_PUSH: ;
      default: ;
    endcase
  end

  // result queue parts the needle model from the consumer
  assign oq_full   = (oq_cnt_r == OQ_CNT_W'(OQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign out_data  = oq_mem_r[oq_rp_r];
  assign oq_pop    = out_pop & ~out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wp_r] <= res_r;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= Q24_ONE)
    else $error("needle position above full scale");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && step_r != DIV_STEP_W'(SUM_W - 1)) |=> state_r == B_DIV)
    else $error("division left early");

  a_clamp_low: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == B_POS && position_r == '0) |-> inertia_r == '0)
    else $error("inertia kept at lower needle stop");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue count out of range");

endmodule
`default_nettype wire

// ===== sim/vmb_checker.sv =====
`timescale 1ns / 1ps
module vmb_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic                       in_full,
  input  vmb_pkg::in_t               in_data,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  vmb_pkg::out_t              out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [vmb_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [vmb_pkg::APB_DW-1:0] cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         mismatches,
  output int                         readings_due
);
  import vmb_pkg::*;

  localparam longint INERTIA_TOP    = (longint'(1) <<< 40) - 1;
  localparam longint INERTIA_BOTTOM = -(longint'(1) <<< 40);
  localparam longint FULL_SCALE     = longint'(Q24_ONE);

  logic [Q_W-1:0]          gain, rise, fall, pcoef, icoef;
  logic [Q_W-1:0]          follower;
  logic [SUM_W-1:0]        block_sum;
  logic [CNT_W-1:0]        sample_cnt;
  logic [Q_W-1:0]          level;
  logic [Q_W-1:0]          position;
  logic signed [INR_W-1:0] inertia;
  logic                    overflow_seen;
  out_t                    due_readings[$];
  out_t                    want;

  initial mismatches = 0;

  // a * c / 2^24, truncated toward zero
  function automatic longint q24_scale(input longint a, input logic [Q_W-1:0] c);
    longint          mag;
    logic [88:0]     prod;
    logic [63:0]     q;
    mag  = (a < 0) ? -a : a;
    prod = mag;
    prod = prod * c;
    q    = prod[87:24];
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic move_needle();
    longint err, acc, next_pos;
    err = longint'(level) - longint'(position);
    acc = longint'(inertia) + err;
    if (acc > INERTIA_TOP) acc = INERTIA_TOP;
    if (acc < INERTIA_BOTTOM) acc = INERTIA_BOTTOM;
    next_pos = longint'(position) + q24_scale(err, pcoef) + q24_scale(acc, icoef);
    if (next_pos <= 0) begin
      next_pos = 0;
      acc = 0;
    end
    if (next_pos >= FULL_SCALE) begin
      next_pos = FULL_SCALE;
      acc = 0;
    end
    position = Q_W'(next_pos);
    inertia  = INR_W'(acc);
  endtask

  task automatic follow_sample(input in_t s);
    int             v;
    logic [41:0]    scaled;
    logic [Q_W-1:0] target, gap;
    v      = s.sample;
    scaled = 42'(v < 0 ? -v : v);
    scaled = scaled * gain;
    target = Q_W'(scaled >> 15);
    if (target >= follower) begin
      gap = target - follower;
      follower = follower + ((gap < rise) ? gap : rise);
    end else begin
      gap = follower - target;
      follower = follower - ((gap < fall) ? gap : fall);
    end
    // past the block limit the follower still moves but nothing is summed
    if (sample_cnt < CNT_W'(MAX_BLOCK)) begin
      block_sum  = block_sum + SUM_W'(follower);
      sample_cnt = sample_cnt + 1'b1;
    end else begin
      overflow_seen = 1'b1;
    end
    if (s.last) begin
      level = (sample_cnt != 0) ? Q_W'(block_sum / SUM_W'(sample_cnt)) : '0;
      move_needle();
      due_readings.push_back('{needle_pos: position, block_level: level,
                               overflow: overflow_seen});
      block_sum     = '0;
      sample_cnt    = '0;
      overflow_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain          = GAIN_RST;
      rise          = RISE_RST;
      fall          = FALL_RST;
      pcoef         = PCOEF_RST;
      icoef         = ICOEF_RST;
      follower      = '0;
      block_sum     = '0;
      sample_cnt    = '0;
      level         = '0;
      position      = '0;
      inertia       = '0;
      overflow_seen = 1'b0;
      due_readings.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        unique case (cfg_paddr[APB_AW-1:2])
          REG_GAIN:  gain  = cfg_pwdata[Q_W-1:0];
          REG_RISE:  rise  = cfg_pwdata[Q_W-1:0];
          REG_FALL:  fall  = cfg_pwdata[Q_W-1:0];
          REG_PCOEF: pcoef = cfg_pwdata[Q_W-1:0];
          REG_ICOEF: icoef = cfg_pwdata[Q_W-1:0];
          default: ;
        endcase
      end
      if (!out_empty && out_pop) begin
        if (due_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reading: expected none, actual pos %0d level %0d ovf %0b",
                   $time, out_data.needle_pos, out_data.block_level, out_data.overflow);
        end else begin
          want = due_readings.pop_front();
          if (out_data.needle_pos !== want.needle_pos ||
              out_data.block_level !== want.block_level ||
              out_data.overflow !== want.overflow) begin
            mismatches++;
            $display("%0t: reading mismatch: expected pos %0d level %0d ovf %0b, actual pos %0d level %0d ovf %0b",
                     $time, want.needle_pos, want.block_level, want.overflow,
                     out_data.needle_pos, out_data.block_level, out_data.overflow);
          end
        end
      end
      if (in_push && !in_full) follow_sample(in_data);
    end
    readings_due = due_readings.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import vmb_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 320;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_t                   in_data;
  logic                  out_empty;
  logic                  out_pop;
  out_t                  out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_AW-1:0]     cfg_paddr;
  logic [APB_DW-1:0]     cfg_pwdata;
  logic [APB_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;
  int                    mismatches;
  int                    readings_due;
  bit                    idle_on;
  int                    cycles;

  vu_meter_ballistics u_dut (.*);

  vmb_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // result side stalls at random while idling is on
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop <= idle_on ? ($urandom_range(0, 99) >= 22) : 1'b1;
    end
  end

  task automatic push_sample(input logic signed [15:0] s, input logic lst);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 22) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{sample: s, last: lst};
    do @(posedge clk); while (in_full);
  endtask

  // hold off until every reading is out and the pipeline has drained
  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (readings_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic load_config(input logic [APB_DW-1:0] g, r, f, p, i);
    write_reg(REG_GAIN, g);
    write_reg(REG_RISE, r);
    write_reg(REG_FALL, f);
    write_reg(REG_PCOEF, p);
    write_reg(REG_ICOEF, i);
  endtask

  function automatic logic [APB_DW-1:0] pick_reg_value(input logic [Q_W-1:0] dflt);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return APB_DW'(Q24_ONE);
      2: return ($urandom() & 32'hFE00_0000) | 32'h01FF_FFFF;
      3: return APB_DW'(dflt);
      4: return $urandom_range(0, 20000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample(input int shift);
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return $signed(16'($urandom())) >>> shift;
    endcase
  endfunction

  task automatic send_block(input int len, input int shift);
    for (int k = 0; k < len; k++) push_sample(pick_sample(shift), k == len - 1);
  endtask

  task automatic run_blocks(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
      send_block(len, $urandom_range(0, 15));
      sent += len;
    end
  endtask

  task automatic load_random_config();
    load_config(pick_reg_value(GAIN_RST), pick_reg_value(RISE_RST),
                pick_reg_value(FALL_RST), pick_reg_value(PCOEF_RST),
                pick_reg_value(ICOEF_RST));
  endtask

  initial begin
    in_push     = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    idle_on     = 1'b1;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: extreme samples, a mixed block and single-sample blocks
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd0, 1'b1);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sd0, 1'b1);
    wait_idle();

    // full gain and unit steps drive the needle to both end stops
    load_config(32'hFFFF_FFFF, APB_DW'(Q24_ONE), APB_DW'(Q24_ONE),
                APB_DW'(Q24_ONE), APB_DW'(Q24_ONE));
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sd0, 1'b1);
    push_sample(16'sd0, 1'b1);
    push_sample(16'sd0, 1'b1);
    wait_idle();

    // all zero, then writes to unmapped indexes that must change nothing
    load_config('0, '0, '0, '0, '0);
    for (int k = REG_ICOEF + 1; k < 8; k++) write_reg(REG_IDX_W'(k), $urandom());
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sd1, 1'b1);
    wait_idle();

    // block one sample past the limit, then a short one
    load_config(APB_DW'(GAIN_RST), 32'd200000, 32'd100000,
                APB_DW'(PCOEF_RST), APB_DW'(ICOEF_RST));
    send_block(MAX_BLOCK + 1, 2);
    send_block(5, 0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      load_random_config();
      idle_on = (ph != 2);
      run_blocks(RANDOM_ITEMS / 8);
      wait_idle();
      run_blocks(RANDOM_ITEMS / 8);
      wait_idle();
    end
    idle_on = 1'b1;

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
